/* hw/rtl/cisa_pkg.sv */
// shared constants and types of the contact identifier slot allocator
`default_nettype none

package cisa_pkg;

   localparam int MAX_SLOTS_DEFAULT = 16;
   localparam int ID_W              = 32;
   localparam int SLOT_W            = 4;
   localparam int CSR_W             = 5;
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   // commands from the sequencer to the slot flag array
   typedef struct packed {
      logic clean;
      logic claim;
      logic down;
   } flag_cmd_type;

endpackage

`default_nettype wire

/* hw/rtl/contact_id_slot_allocator.sv */
// top level of the contact identifier slot allocator
`default_nettype none

// maps a touch contact identifier to a small slot number
//
// input channel: req_contact_id and req_lifted are taken at a rising edge
// with start high and busy low; busy stays high until the result is out
// result channel: rsp_slot, rsp_found and rsp_all_up are shown for one
// cycle with rsp_valid high; the receiver cannot stall, so the word is
// gone after that cycle
// configuration: csr_wdata is written to slots_in_use at an edge with
// csr_we high; values above MAX_SLOTS act as MAX_SLOTS
//
// order of work: the owner memory is read one slot a cycle while the slot
// read before is checked; a miss over the full first scan of the active
// slots leads to the cleanup and a second scan over the flags; a slot
// found in either scan is claimed in the claim state, then the result
// state follows; the next word is taken the cycle after the result, so
// no new word is taken before the last one is out
//
// reset clears all valid and down flags and sets slots_in_use to 16; the
// owner memory keeps no reset and its data only counts where the valid flag is set

module contact_id_slot_allocator #(
   parameter int MAX_SLOTS = cisa_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   // input channel
   input  wire                          start,
   output logic                         busy,
   input  wire [cisa_pkg::ID_W-1:0]     req_contact_id,
   input  wire                          req_lifted,
   // result channel
   output logic                         rsp_valid,
   output logic [cisa_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                         rsp_found,
   output logic                         rsp_all_up,
   // configuration
   input  wire                          csr_we,
   input  wire [cisa_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int WIDE_W = (CNT_W > cisa_pkg::CSR_W) ? CNT_W : cisa_pkg::CSR_W;
   localparam int ID_W   = cisa_pkg::ID_W;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,   // owner memory scan, one read a cycle
      ST_CLEAN  = 6'b000100,   // free slots that are not down
      ST_SCAN2  = 6'b001000,   // second scan for a free slot
      ST_CLAIM  = 6'b010000,   // write owner and flags
      ST_RESULT = 6'b100000    // result word on the rsp ports
   } state_type;

   state_type state_ff, state_in;

   logic [cisa_pkg::CSR_W-1:0] csr_ff;
   logic [ID_W-1:0]            id_ff, id_in;
   logic                       lifted_ff, lifted_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [IDX_W-1:0]           scan_idx_ff, scan_idx_in;
   logic                       issue_ff, issue_in;
   logic [IDX_W-1:0]           chk_idx_ff, chk_idx_in;
   logic                       chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]           hit_ff, hit_in;
   logic                       found_ff, found_in;
   logic [ID_W-1:0]            rd_data_ff;

   // owner memory with a registered read
   logic [ID_W-1:0]            owner_mem [MAX_SLOTS];
   logic                       mem_we;

   // flag array interface
   cisa_pkg::flag_cmd_type     flag_cmd;
   logic [IDX_W-1:0]           flag_idx;
   logic                       flag_valid;
   logic                       flag_all_up;

   // active slot count, saturated to the table size
   logic [WIDE_W-1:0]          csr_wide;
   logic [CNT_W-1:0]           n_eff;
   logic [IDX_W-1:0]           last_idx;

   assign csr_wide = WIDE_W'(csr_ff);
   assign n_eff    = (csr_wide > WIDE_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(csr_wide);
   assign last_idx = IDX_W'(n_ff - CNT_W'(1));

   always_comb begin
      state_in    = state_ff;
      id_in       = id_ff;
      lifted_in   = lifted_ff;
      n_in        = n_ff;
      scan_idx_in = scan_idx_ff;
      issue_in    = issue_ff;
      chk_idx_in  = chk_idx_ff;
      chk_vld_in  = 1'b0;
      hit_in      = hit_ff;
      found_in    = found_ff;
      flag_cmd    = '0;
      flag_idx    = hit_ff;
      mem_we      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               id_in       = req_contact_id;
               lifted_in   = req_lifted;
               n_in        = n_eff;
               scan_idx_in = '0;
               issue_in    = 1'b1;
               hit_in      = '0;
               found_in    = 1'b0;
               // no active slots: nothing to scan
               state_in    = (n_eff == '0) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            flag_idx = chk_idx_ff;
            // issue the next read while the previous one is checked
            if (issue_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_idx_ff;
               if (scan_idx_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = IDX_W'(scan_idx_ff + 1'b1);
               end
            end
            if (chk_vld_ff) begin
               if (!flag_valid || rd_data_ff == id_ff) begin
                  hit_in   = chk_idx_ff;
                  found_in = 1'b1;
                  state_in = ST_CLAIM;
               end else if (chk_idx_ff == last_idx) begin
                  state_in = ST_CLEAN;
               end
            end
         end
         ST_CLEAN: begin
            flag_cmd.clean = 1'b1;
            scan_idx_in    = '0;
            state_in       = ST_SCAN2;
         end
         ST_SCAN2: begin
            // no owner matched, so only a freed slot can qualify now
            flag_idx = scan_idx_ff;
            if (!flag_valid) begin
               hit_in   = scan_idx_ff;
               found_in = 1'b1;
               state_in = ST_CLAIM;
            end else if (scan_idx_ff == last_idx) begin
               state_in = ST_RESULT;
            end else begin
               scan_idx_in = IDX_W'(scan_idx_ff + 1'b1);
            end
         end
         ST_CLAIM: begin
            flag_cmd.claim = 1'b1;
            flag_cmd.down  = !lifted_ff;
            mem_we         = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         csr_ff     <= cisa_pkg::CSR_RESET;
         issue_ff   <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         chk_vld_ff <= chk_vld_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      lifted_ff   <= lifted_in;
      n_ff        <= n_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
   end

   // the only write is in the claim state and the next read only comes after
   // the result and idle states, so read and write never meet on one entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         owner_mem[hit_ff] <= id_ff;
      end
      if (state_ff == ST_SCAN && issue_ff) begin
         rd_data_ff <= owner_mem[scan_idx_ff];
      end
   end

   cisa_flags #(
      .MAX_SLOTS (MAX_SLOTS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_flags (
      .clock        (clock),
      .reset        (reset),
      .cmd          (flag_cmd),
      .idx          (flag_idx),
      .n_active     (n_ff),
      .valid_at_idx (flag_valid),
      .all_up       (flag_all_up)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESULT);
   assign rsp_slot   = cisa_pkg::SLOT_W'(hit_ff);
   assign rsp_found  = found_ff;
   assign rsp_all_up = flag_all_up;

`ifndef ASSERT_OFF
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not make the block busy");

   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block stayed busy after the result word");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> CNT_W'(hit_ff) < n_ff)
      else $error("assigned slot outside the active range");

   a_found_was_claimed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> $past(state_ff == ST_CLAIM))
      else $error("found reported without a claim cycle");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cisa_flags.sv */
// per-slot valid and down flags with cleanup, claim and all-up test
`default_nettype none

module cisa_flags #(
   parameter int MAX_SLOTS = cisa_pkg::MAX_SLOTS_DEFAULT,
   parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire cisa_pkg::flag_cmd_type cmd,
   input  wire [IDX_W-1:0]             idx,
   input  wire [CNT_W-1:0]             n_active,
   output logic                        valid_at_idx,
   output logic                        all_up
);

   logic [MAX_SLOTS-1:0] valid_ff, valid_in;
   logic [MAX_SLOTS-1:0] down_ff, down_in;
   logic [MAX_SLOTS-1:0] active;

   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         active[i] = (CNT_W'(i) < n_active);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      down_in  = down_ff;
      // free every active slot whose contact is not down
      if (cmd.clean) begin
         valid_in = valid_ff & (down_ff | ~active);
      end
      if (cmd.claim) begin
         valid_in[idx] = 1'b1;
         down_in[idx]  = cmd.down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         down_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         down_ff  <= down_in;
      end
   end

   assign valid_at_idx = valid_ff[idx];
   assign all_up       = ~|(down_ff & active);

endmodule

`default_nettype wire

/* sim/tb_contact_id_slot_allocator.sv */
// testbench of the contact identifier slot allocator with its slot table scoreboard
`timescale 1ns / 100ps

class slot_table_checker;
   localparam int SLOTS  = cisa_pkg::MAX_SLOTS_DEFAULT;
   localparam int ID_W   = cisa_pkg::ID_W;
   localparam int SLOT_W = cisa_pkg::SLOT_W;
   localparam int CSR_W  = cisa_pkg::CSR_W;

   typedef struct {
      logic [ID_W-1:0]   contact_id;
      logic [SLOT_W-1:0] slot;
      logic              found;
      logic              all_up;
   } assignment_type;

   logic              slot_valid [SLOTS];
   logic [ID_W-1:0]   slot_owner [SLOTS];
   logic              slot_down  [SLOTS];
   logic [CSR_W-1:0]  slots_in_use;
   assignment_type    expected_assignments [$];
   int                mismatches;

   function void clear();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_owner[i] = '0;
         slot_down[i]  = 1'b0;
      end
      slots_in_use = cisa_pkg::CSR_RESET;
      expected_assignments.delete();
   endfunction

   function void write_slots_in_use(input logic [CSR_W-1:0] value);
      slots_in_use = value;
   endfunction

   function int pending();
      return expected_assignments.size();
   endfunction

   // first active slot that is free or already held by this contact
   function int first_open_slot(input logic [ID_W-1:0] id, input int n);
      int i;
      for (i = 0; i < n; i++)
         if (!slot_valid[i] || slot_owner[i] == id) return i;
      return -1;
   endfunction

   // predicts the assignment of an accepted contact and updates the table
   function void note_contact(input logic [ID_W-1:0] id, input logic lifted);
      int             n;
      int             hit;
      int             i;
      assignment_type a;
      n = (slots_in_use > SLOTS) ? SLOTS : int'(slots_in_use);
      hit = first_open_slot(id, n);
      if (hit < 0) begin
         // free every slot whose contact is up, then try again
         for (i = 0; i < n; i++)
            if (!slot_down[i]) slot_valid[i] = 1'b0;
         hit = first_open_slot(id, n);
      end
      if (hit >= 0) begin
         slot_valid[hit] = 1'b1;
         slot_owner[hit] = id;
         slot_down[hit]  = !lifted;
      end
      a.contact_id = id;
      a.found      = (hit >= 0);
      a.slot       = (hit >= 0) ? SLOT_W'(hit) : '0;
      a.all_up     = 1'b1;
      for (i = 0; i < n; i++)
         if (slot_down[i]) a.all_up = 1'b0;
      expected_assignments.push_back(a);
   endfunction

   function void check_assignment(input logic [SLOT_W-1:0] slot, input logic found,
                                  input logic all_up);
      assignment_type a;
      if (expected_assignments.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word: slot %0d found %b all_up %b",
                     slot, found, all_up);
         return;
      end
      a = expected_assignments.pop_front();
      if (slot !== a.slot || found !== a.found || all_up !== a.all_up) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch for contact %h: expected slot %0d found %b all_up %b,",
                      " got slot %0d found %b all_up %b"},
                     a.contact_id, a.slot, a.found, a.all_up, slot, found, all_up);
      end
   endfunction
endclass

module tb_contact_id_slot_allocator;
   localparam int TABLE_SIZE  = cisa_pkg::MAX_SLOTS_DEFAULT;
   // the limit is several times what roughly 1650 words need at the worst
   // case, each with the longest sender gap
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 40;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [cisa_pkg::ID_W-1:0]     req_contact_id;
   logic                          req_lifted;
   logic                          rsp_valid;
   logic [cisa_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          rsp_found;
   logic                          rsp_all_up;
   logic                          csr_we;
   logic [cisa_pkg::CSR_W-1:0]    csr_wdata;

   slot_table_checker table_chk;
   int                cycle_count;
   bit                quiet;   // no sender idling while set

   contact_id_slot_allocator #(.MAX_SLOTS(TABLE_SIZE)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_contact_id (req_contact_id),
      .req_lifted     (req_lifted),
      .rsp_valid      (rsp_valid),
      .rsp_slot       (rsp_slot),
      .rsp_found      (rsp_found),
      .rsp_all_up     (rsp_all_up),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a lost word or a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // monitor: everything sampled here is the value from before the edge,
   // so the register write, the accepted word and the result word are all
   // seen as the block sees them
   always @(posedge clock) begin
      if (reset) begin
         table_chk.clear();
      end else begin
         if (csr_we) table_chk.write_slots_in_use(csr_wdata);
         // a result always belongs to an older word than one taken now
         if (rsp_valid) table_chk.check_assignment(rsp_slot, rsp_found, rsp_all_up);
         if (start && !busy) table_chk.note_contact(req_contact_id, req_lifted);
      end
   end

   // present one contact word and return at the edge that takes it;
   // start stays high into the next word unless the sender idles first
   task automatic send_contact(input logic [cisa_pkg::ID_W-1:0] id, input logic lifted);
      if (!quiet && $urandom_range(99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 48)) @(posedge clock);
      end
      start          <= 1'b1;
      req_contact_id <= id;
      req_lifted     <= lifted;
      do @(posedge clock); while (busy);
   endtask

   // drop start and wait until the block is idle and every predicted word
   // has come back
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (busy || table_chk.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only issued while the block is idle
   task automatic program_slots_in_use(input logic [cisa_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // random phase: contacts mostly come from a small set of fingers so that
   // repeat touches, cleanup and a full table all happen, with some noise
   // identifiers mixed in
   task automatic run_random_phase(input logic [cisa_pkg::CSR_W-1:0] setting,
                                   input int count, input int first_index);
      logic [cisa_pkg::ID_W-1:0] fingers [0:TABLE_SIZE+3];
      logic [cisa_pkg::ID_W-1:0] id;
      int                        n_eff;
      int                        finger_count;
      int                        k;
      n_eff = (setting > TABLE_SIZE) ? TABLE_SIZE : int'(setting);
      finger_count = $urandom_range(1, n_eff + 4);
      for (k = 0; k < finger_count; k++) begin
         case ($urandom_range(19))
            0:       fingers[k] = '0;
            1:       fingers[k] = '1;
            default: fingers[k] = $urandom();
         endcase
      end
      program_slots_in_use(setting);
      for (k = 0; k < count; k++) begin
         // one long stretch in the middle of the run has no sender gaps
         quiet = (first_index + k >= 600) && (first_index + k < 1000);
         if ($urandom_range(99) < 10) id = $urandom();
         else id = fingers[$urandom_range(finger_count - 1)];
         send_contact(id, $urandom_range(99) < 25);
      end
      settle();
   endtask

   initial begin
      logic [cisa_pkg::CSR_W-1:0] settings [10];
      int                         p;

      table_chk = new();
      quiet = 1'b0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_contact_id <= '0;
      req_lifted     <= 1'b0;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register at its reset value of 16: identifier extremes, repeat
      // touch of an owned slot and lift-off
      send_contact(32'h0000_0000, 1'b0);
      send_contact(32'hFFFF_FFFF, 1'b0);
      send_contact(32'h0000_0000, 1'b1);
      send_contact(32'h8000_0001, 1'b1);
      send_contact(32'h7FFF_FFFE, 1'b0);
      settle();

      // two active slots: cleanup reclaims an up slot, then the table is
      // full with both contacts down, then a lift lets the next one in
      program_slots_in_use(5'd2);
      send_contact(32'h0000_0055, 1'b0);
      send_contact(32'h0000_00AA, 1'b0);
      send_contact(32'hFFFF_FFFF, 1'b1);
      send_contact(32'h0000_00AA, 1'b0);
      settle();

      // no active slots: nothing assigned and everything counts as up
      program_slots_in_use(5'd0);
      send_contact(32'h1234_5678, 1'b0);
      send_contact(32'hFFFF_FFFF, 1'b1);
      settle();

      // register above table size saturates; slots left alone while the
      // range was small still hold their old contacts
      program_slots_in_use(5'd31);
      send_contact(32'h7FFF_FFFE, 1'b1);
      send_contact(32'h8000_0001, 1'b0);
      send_contact(32'hDEAD_BEEF, 1'b0);
      settle();
      program_slots_in_use(5'd17);
      send_contact(32'hDEAD_BEEF, 1'b1);
      settle();

      // single slot, still held down by contact 55 from earlier: neither finger gets in, down or lifted
      program_slots_in_use(5'd1);
      send_contact(32'h0000_0001, 1'b0);
      send_contact(32'h0000_0002, 1'b0);
      send_contact(32'h0000_0001, 1'b1);
      send_contact(32'h0000_0002, 1'b1);
      settle();

      settings = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd7, 5'd17, 5'd12, 5'd16, 5'd2};
      for (p = 0; p < 10; p++)
         run_random_phase(settings[p], 160, p * 160);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (table_chk.mismatches == 0 && table_chk.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
